// ===== rtl/core/htb_pkg.sv =====
// shared types, register codes and constants for the hann tone burst generator
// depends on nothing; used by the interfaces and every module of the block
`default_nettype none

package htb_pkg;

    localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;
    localparam int SAMPLE_WIDTH_DEFAULT     = 16;
    localparam int PHASE_WIDTH_DEFAULT      = 32;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERIOD_LEN        = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BURST_LEN         = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BURST_COUNT       = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TONE_PHASE_STEP   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_PHASE_STEP = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AMPLITUDE         = 3'd5;

    localparam logic [23:0] PERIOD_LEN_RESET        = 24'd96000;
    localparam logic [15:0] BURST_LEN_RESET         = 16'd240;
    localparam logic [15:0] BURST_COUNT_RESET       = 16'd100;
    localparam logic [31:0] TONE_PHASE_STEP_RESET   = 32'd178956971;
    localparam logic [31:0] WINDOW_PHASE_STEP_RESET = 32'd17970591;
    localparam logic [14:0] AMPLITUDE_RESET         = 15'd22938;

    // shared multiplier operands and product
    localparam int MUL_WIDTH  = 17;
    localparam int PROD_WIDTH = 2 * MUL_WIDTH;

    // sine polynomial coefficients, q16
    localparam logic [MUL_WIDTH-1:0] POLY_K0 = 17'd42111;
    localparam logic [MUL_WIDTH-1:0] POLY_K1 = 17'd4728;
    localparam logic [MUL_WIDTH-1:0] POLY_K2 = 17'd102919;
    localparam logic [MUL_WIDTH-1:0] X_ONE   = 17'd65536;
    localparam logic [14:0]          MAG_MAX = 15'd32767;

    typedef struct packed {
        logic [23:0] period_len;
        logic [15:0] burst_len;
        logic [15:0] burst_count;
        logic [31:0] tone_phase_step;
        logic [31:0] window_phase_step;
        logic [14:0] amplitude;
    } htb_cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD_X,
        OP_SQUARE,
        OP_POLY_A,
        OP_POLY_B,
        OP_POLY_C,
        OP_STORE,
        OP_GAIN,
        OP_SCALE
    } htb_op_t;

    typedef enum logic {
        SEL_COS,
        SEL_SIN
    } htb_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD,
        ST_SQUARE,
        ST_POLY_A,
        ST_POLY_B,
        ST_POLY_C,
        ST_STORE,
        ST_GAIN,
        ST_SCALE,
        ST_OUT
    } htb_state_t;

    typedef struct packed {
        htb_op_t  op;
        htb_sel_t sel;
        logic     load_out;
    } htb_cmd_t;

    typedef struct packed {
        logic in_burst;
    } htb_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/htb_interfaces.sv =====
// valid/ready channel interfaces: tick input, sample result and config write
// depends on htb_pkg for widths
`default_nettype none

interface htb_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface htb_out_if #(
    parameter int SAMPLE_WIDTH = htb_pkg::SAMPLE_WIDTH_DEFAULT
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           in_burst;
    logic                           last_of_train;
    logic                           finished;
    logic                           config_error;

    modport source (output valid, output sample, output in_burst, output last_of_train,
                    output finished, output config_error, input ready);
    modport sink (input valid, input sample, input in_burst, input last_of_train,
                  input finished, input config_error, output ready);
endinterface

interface htb_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [htb_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [htb_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/htb_cfg_regs.sv =====
// configuration register file, written through the config channel
// depends on htb_pkg and htb_cfg_if
`default_nettype none

module htb_cfg_regs (
    input  wire               clk,
    input  wire               rst_n,
    htb_cfg_if.sink           cfg,
    output htb_pkg::htb_cfg_t regs
);

    htb_pkg::htb_cfg_t regs_reg;
    htb_pkg::htb_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                htb_pkg::REG_PERIOD_LEN:        regs_next.period_len = cfg.data[23:0];
                htb_pkg::REG_BURST_LEN:         regs_next.burst_len = cfg.data[15:0];
                htb_pkg::REG_BURST_COUNT:       regs_next.burst_count = cfg.data[15:0];
                htb_pkg::REG_TONE_PHASE_STEP:   regs_next.tone_phase_step = cfg.data;
                htb_pkg::REG_WINDOW_PHASE_STEP: regs_next.window_phase_step = cfg.data;
                htb_pkg::REG_AMPLITUDE:         regs_next.amplitude = cfg.data[14:0];
                default:                        regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.period_len        <= htb_pkg::PERIOD_LEN_RESET;
            regs_reg.burst_len         <= htb_pkg::BURST_LEN_RESET;
            regs_reg.burst_count       <= htb_pkg::BURST_COUNT_RESET;
            regs_reg.tone_phase_step   <= htb_pkg::TONE_PHASE_STEP_RESET;
            regs_reg.window_phase_step <= htb_pkg::WINDOW_PHASE_STEP_RESET;
            regs_reg.amplitude         <= htb_pkg::AMPLITUDE_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/htb_ctrl.sv =====
// sequencer: steps the shared multiplier through cosine, sine, gain and scale
// depends on htb_pkg
`default_nettype none

module htb_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    output htb_pkg::htb_cmd_t    cmd,
    input  htb_pkg::htb_status_t status
);

    htb_pkg::htb_state_t state_reg;
    htb_pkg::htb_state_t state_next;
    htb_pkg::htb_sel_t   sel_reg;
    htb_pkg::htb_sel_t   sel_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= htb_pkg::ST_IDLE;
            sel_reg       <= htb_pkg::SEL_COS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd.op         = htb_pkg::OP_NONE;
        cmd.sel        = sel_reg;
        cmd.load_out   = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            htb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = htb_pkg::OP_ACCEPT;
                    sel_next   = htb_pkg::SEL_COS;
                    state_next = htb_pkg::ST_DISPATCH;
                end
            end
            htb_pkg::ST_DISPATCH:
            begin
                cmd.op     = htb_pkg::OP_LOAD_X;
                cmd.sel    = htb_pkg::SEL_COS;
                state_next = status.in_burst ? htb_pkg::ST_SQUARE : htb_pkg::ST_OUT;
            end
            htb_pkg::ST_LOAD:
            begin
                cmd.op     = htb_pkg::OP_LOAD_X;
                state_next = htb_pkg::ST_SQUARE;
            end
            htb_pkg::ST_SQUARE:
            begin
                cmd.op     = htb_pkg::OP_SQUARE;
                state_next = htb_pkg::ST_POLY_A;
            end
            htb_pkg::ST_POLY_A:
            begin
                cmd.op     = htb_pkg::OP_POLY_A;
                state_next = htb_pkg::ST_POLY_B;
            end
            htb_pkg::ST_POLY_B:
            begin
                cmd.op     = htb_pkg::OP_POLY_B;
                state_next = htb_pkg::ST_POLY_C;
            end
            htb_pkg::ST_POLY_C:
            begin
                cmd.op     = htb_pkg::OP_POLY_C;
                state_next = htb_pkg::ST_STORE;
            end
            htb_pkg::ST_STORE:
            begin
                cmd.op = htb_pkg::OP_STORE;
                if (sel_reg == htb_pkg::SEL_COS)
                begin
                    sel_next   = htb_pkg::SEL_SIN;
                    state_next = htb_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = htb_pkg::ST_GAIN;
                end
            end
            htb_pkg::ST_GAIN:
            begin
                cmd.op     = htb_pkg::OP_GAIN;
                state_next = htb_pkg::ST_SCALE;
            end
            htb_pkg::ST_SCALE:
            begin
                cmd.op     = htb_pkg::OP_SCALE;
                state_next = htb_pkg::ST_OUT;
            end
            htb_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = htb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = htb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/htb_datapath.sv =====
// train counters, phase accumulators, sine polynomial on a shared multiplier,
// gain and rounding, and the output register; depends on htb_pkg
`default_nettype none

module htb_datapath #(
    parameter int SINE_TABLE_DEPTH = htb_pkg::SINE_TABLE_DEPTH_DEFAULT,
    parameter int SAMPLE_WIDTH     = htb_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int PHASE_WIDTH      = htb_pkg::PHASE_WIDTH_DEFAULT
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  htb_pkg::htb_cfg_t              cfg,
    input  wire                            restart,
    input  htb_pkg::htb_cmd_t              cmd,
    output htb_pkg::htb_status_t           status,
    output logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           in_burst,
    output logic                           last_of_train,
    output logic                           finished,
    output logic                           config_error
);

    localparam int TABLE_BITS  = $clog2(SINE_TABLE_DEPTH);
    localparam int FRAC_BITS   = TABLE_BITS - 2;
    localparam int X_SHIFT     = 18 - TABLE_BITS;
    localparam int ROUND_SHIFT = 31 - SAMPLE_WIDTH;
    localparam int MW          = htb_pkg::MUL_WIDTH;
    localparam int PW          = htb_pkg::PROD_WIDTH;
    localparam logic [PHASE_WIDTH-1:0] QUARTER = {2'b01, {(PHASE_WIDTH - 2){1'b0}}};

    // train state
    logic [23:0]            pos_reg;
    logic [23:0]            pos_next;
    logic [15:0]            bn_reg;
    logic [15:0]            bn_next;
    logic [PHASE_WIDTH-1:0] tph_reg;
    logic [PHASE_WIDTH-1:0] tph_next;
    logic [PHASE_WIDTH-1:0] wph_reg;
    logic [PHASE_WIDTH-1:0] wph_next;
    logic                   done_reg;
    logic                   done_next;

    logic [23:0]            pos_eff;
    logic [15:0]            bn_eff;
    logic [PHASE_WIDTH-1:0] tph_eff;
    logic [PHASE_WIDTH-1:0] wph_eff;
    logic                   done_eff;
    logic [PHASE_WIDTH-1:0] tph_start;
    logic [PHASE_WIDTH-1:0] wph_start;
    logic [PHASE_WIDTH-1:0] tone_step;
    logic [PHASE_WIDTH-1:0] win_step;
    logic [PHASE_WIDTH-1:0] cos_phase;
    logic                   cfg_bad;
    logic                   over;
    logic                   in_b;
    logic                   eop;
    logic                   last;

    // per item working registers
    logic                  res_in_burst_reg;
    logic                  res_last_reg;
    logic                  res_finished_reg;
    logic                  res_error_reg;
    logic [TABLE_BITS-1:0] cos_idx_reg;
    logic [TABLE_BITS-1:0] sin_idx_reg;
    logic [MW-1:0]         x_reg;
    logic [1:0]            quad_reg;
    logic [MW-1:0]         x2_reg;
    logic [PW-1:0]         prod_reg;
    logic signed [15:0]    cos_reg;
    logic [14:0]           sin_mag_reg;
    logic                  sin_neg_reg;

    logic [TABLE_BITS-1:0]   idx_sel;
    logic [MW-1:0]           x_base;
    logic [MW-1:0]           x_load;
    logic [MW-1:0]           x2_cur;
    logic [MW-1:0]           p1;
    logic [MW-1:0]           p2;
    logic [17:0]             y_inc;
    logic [MW-1:0]           y_half;
    logic [14:0]             mag;
    logic signed [15:0]      mag_signed;
    logic [16:0]             win_diff;
    logic [29:0]             g_sum;
    logic [30:0]             m_sum;
    logic [SAMPLE_WIDTH-1:0] m_val;
    logic [SAMPLE_WIDTH-1:0] sample_val;
    logic [MW-1:0]           mul_a;
    logic [MW-1:0]           mul_b;
    logic [PW-1:0]           prod_next;

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           in_burst_reg;
    logic                           last_reg;
    logic                           finished_reg;
    logic                           error_reg;

    assign status.in_burst = res_in_burst_reg;
    assign sample          = sample_reg;
    assign in_burst        = in_burst_reg;
    assign last_of_train   = last_reg;
    assign finished        = finished_reg;
    assign config_error    = error_reg;

    // train sequencing for one tick
    always_comb
    begin
        pos_eff   = restart ? '0 : pos_reg;
        bn_eff    = restart ? '0 : bn_reg;
        tph_eff   = restart ? '0 : tph_reg;
        wph_eff   = restart ? '0 : wph_reg;
        done_eff  = restart ? 1'b0 : done_reg;
        tone_step = PHASE_WIDTH'(cfg.tone_phase_step);
        win_step  = PHASE_WIDTH'(cfg.window_phase_step);

        cfg_bad = (cfg.burst_len < 16'd2) || (cfg.period_len <= 24'(cfg.burst_len))
                  || (cfg.burst_count == 16'd0);
        over    = done_eff || (bn_eff >= cfg.burst_count);

        tph_start = (pos_eff == 24'd0) ? '0 : tph_eff;
        wph_start = (pos_eff == 24'd0) ? '0 : wph_eff;
        cos_phase = wph_start + QUARTER;
        in_b      = pos_eff < 24'(cfg.burst_len);
        eop       = pos_eff >= (cfg.period_len - 24'd1);
        last      = eop && (bn_eff == (cfg.burst_count - 16'd1));

        pos_next  = pos_eff;
        bn_next   = bn_eff;
        tph_next  = tph_eff;
        wph_next  = wph_eff;
        done_next = done_eff;
        if (!cfg_bad)
        begin
            if (over)
            begin
                done_next = 1'b1;
            end
            else
            begin
                tph_next  = in_b ? (tph_start + tone_step) : tph_start;
                wph_next  = in_b ? (wph_start + win_step) : wph_start;
                pos_next  = eop ? 24'd0 : (pos_eff + 24'd1);
                bn_next   = eop ? (bn_eff + 16'd1) : bn_eff;
                done_next = last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            bn_reg   <= '0;
            tph_reg  <= '0;
            wph_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (cmd.op == htb_pkg::OP_ACCEPT)
        begin
            pos_reg  <= pos_next;
            bn_reg   <= bn_next;
            tph_reg  <= tph_next;
            wph_reg  <= wph_next;
            done_reg <= done_next;
        end
    end

    // sine polynomial, window, gain and rounding
    always_comb
    begin
        idx_sel = (cmd.sel == htb_pkg::SEL_COS) ? cos_idx_reg : sin_idx_reg;
        x_base  = MW'(idx_sel[FRAC_BITS-1:0]) << X_SHIFT;
        x_load  = idx_sel[FRAC_BITS] ? (htb_pkg::X_ONE - x_base) : x_base;

        x2_cur = prod_reg[32:16];
        p1     = htb_pkg::POLY_K0 - prod_reg[32:16];
        p2     = htb_pkg::POLY_K2 - prod_reg[32:16];

        y_inc      = {1'b0, prod_reg[32:16]} + 18'd1;
        y_half     = y_inc[17:1];
        mag        = (y_half > MW'(htb_pkg::MAG_MAX)) ? htb_pkg::MAG_MAX : y_half[14:0];
        mag_signed = quad_reg[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        win_diff = 17'h08000 - {cos_reg[15], cos_reg};
        g_sum    = prod_reg[29:0] + 30'd16384;

        m_sum      = 31'(prod_reg[29:0]) + (31'd1 << (ROUND_SHIFT - 1));
        m_val      = SAMPLE_WIDTH'(m_sum >> ROUND_SHIFT);
        sample_val = sin_neg_reg ? (-m_val) : m_val;

        unique case (cmd.op)
            htb_pkg::OP_SQUARE:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            htb_pkg::OP_POLY_A:
            begin
                mul_a = htb_pkg::POLY_K1;
                mul_b = x2_cur;
            end
            htb_pkg::OP_POLY_B:
            begin
                mul_a = p1;
                mul_b = x2_reg;
            end
            htb_pkg::OP_POLY_C:
            begin
                mul_a = p2;
                mul_b = x_reg;
            end
            htb_pkg::OP_GAIN:
            begin
                mul_a = MW'(cfg.amplitude);
                mul_b = MW'(win_diff[15:1]);
            end
            htb_pkg::OP_SCALE:
            begin
                mul_a = MW'(g_sum[29:15]);
                mul_b = MW'(sin_mag_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == htb_pkg::OP_ACCEPT)
        begin
            res_error_reg    <= cfg_bad;
            res_finished_reg <= !cfg_bad && over;
            res_in_burst_reg <= !cfg_bad && !over && in_b;
            res_last_reg     <= !cfg_bad && !over && last;
            cos_idx_reg      <= cos_phase[PHASE_WIDTH-1 -: TABLE_BITS];
            sin_idx_reg      <= tph_start[PHASE_WIDTH-1 -: TABLE_BITS];
        end
        if (cmd.op == htb_pkg::OP_LOAD_X)
        begin
            x_reg    <= x_load;
            quad_reg <= idx_sel[TABLE_BITS-1 -: 2];
        end
        if (cmd.op == htb_pkg::OP_POLY_A)
        begin
            x2_reg <= x2_cur;
        end
        if (cmd.op == htb_pkg::OP_SQUARE || cmd.op == htb_pkg::OP_POLY_A
            || cmd.op == htb_pkg::OP_POLY_B || cmd.op == htb_pkg::OP_POLY_C
            || cmd.op == htb_pkg::OP_GAIN || cmd.op == htb_pkg::OP_SCALE)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.op == htb_pkg::OP_STORE)
        begin
            if (cmd.sel == htb_pkg::SEL_COS)
            begin
                cos_reg <= mag_signed;
            end
            else
            begin
                sin_mag_reg <= mag;
                sin_neg_reg <= quad_reg[1];
            end
        end
        if (cmd.load_out)
        begin
            sample_reg   <= res_in_burst_reg ? $signed(sample_val) : '0;
            in_burst_reg <= res_in_burst_reg;
            last_reg     <= res_last_reg;
            finished_reg <= res_finished_reg;
            error_reg    <= res_error_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hann_tone_burst_generator.sv =====
// top level of the hann windowed tone burst generator
// depends on htb_pkg, the htb interfaces, htb_cfg_regs, htb_ctrl and htb_datapath
//
// usage:
//   tick   : one item per output sample; restart = 1 starts the train over at
//            sample zero before that item is processed
//   result : one item per tick: sample, in_burst, last_of_train, finished and
//            config_error
//   cfg    : register writes by index (period_len, burst_len, burst_count,
//            tone_phase_step, window_phase_step, amplitude); always ready,
//            write only while no tick is in flight
// sequence:
//   a burst sample is worked on in turn by the one shared 17x17 multiplier,
//   stepping through the cosine and sine polynomials, the gain and the final
//   scale; a silent sample skips the multiplier and goes straight to the output;
//   the next tick is taken only once the result of the last one is loaded
// reset:
//   clears the train state and loads the default register values; no result
//   is pending afterwards
// stall:
//   a finished result waits in the output register; the next tick is still
//   taken and worked on, and is held until the output register is free
`default_nettype none

module hann_tone_burst_generator #(
    parameter int SINE_TABLE_DEPTH = htb_pkg::SINE_TABLE_DEPTH_DEFAULT,
    parameter int SAMPLE_WIDTH     = htb_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int PHASE_WIDTH      = htb_pkg::PHASE_WIDTH_DEFAULT
) (
    input wire        clk,
    input wire        rst_n,
    htb_in_if.sink    tick,
    htb_out_if.source result,
    htb_cfg_if.sink   cfg
);

    htb_pkg::htb_cfg_t    regs;
    htb_pkg::htb_cmd_t    cmd;
    htb_pkg::htb_status_t status;
    logic                 in_ready;
    logic                 out_valid;

    assign tick.ready   = in_ready;
    assign result.valid = out_valid;

    htb_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    htb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    htb_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .PHASE_WIDTH      (PHASE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (regs),
        .restart       (tick.restart),
        .cmd           (cmd),
        .status        (status),
        .sample        (result.sample),
        .in_burst      (result.in_burst),
        .last_of_train (result.last_of_train),
        .finished      (result.finished),
        .config_error  (result.config_error)
    );

endmodule

`default_nettype wire
